// ===== sv/rotation_matrix_to_euler_angles_macros.svh =====
// Assertion macros for the rotation matrix to Euler angles block.
// Used by the checker file; no other dependencies.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_MACROS_SVH

// same-cycle implication, disabled in reset
`define RMTE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RMTE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rmte_pkg.sv =====
// Shared constants and elaboration-time table functions for the
// rotation matrix to Euler angles block. No dependencies.
`default_nettype none

package rmte_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int MAX_STAGES = 62;
  localparam int SQRT_STEPS = 32;
  localparam logic [30:0] THRESH_RESET = 31'd1074;
  localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A94;
  localparam logic signed [41:0] DEG_LIMIT = 42'sd754974720;

  // stages actually run by one CORDIC unit
  function automatic int cordic_n(input int stages);
    cordic_n = (stages > MAX_STAGES) ? MAX_STAGES : stages;
  endfunction

  // CORDIC unit latency: pre-rotation, iterations, degree conversion
  function automatic int cordic_lat(input int stages);
    cordic_lat = cordic_n(stages) + 2;
  endfunction

  // restoring divide, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    udiv64 = q;
  endfunction

  // atan(2^-i) in half turns, 62 fraction bits
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    logic [127:0] prod;
    int k;
    rad = '0;
    k = 0;
    if (i == 0) begin
      atan_entry = 64'd1 << 60;
    end else begin
      while (62 - i * (2 * k + 1) >= 0) begin
        term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        if (k % 2 == 1) rad = rad - term;
        else rad = rad + term;
        k = k + 1;
      end
      prod = {64'd0, rad} * {64'd0, INV_PI_Q64};
      atan_entry = prod[127:64];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/rmte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on rmte_pkg.
`default_nettype none

module rmte_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [63:0] radicand,
  output logic             out_valid,
  output logic [31:0]      root
);
  import rmte_pkg::*;

  logic [63:0] rem_q [0:SQRT_STEPS];
  logic [63:0] res_q [0:SQRT_STEPS];
  logic        vld   [0:SQRT_STEPS];

  assign rem_q[0] = radicand;
  assign res_q[0] = '0;
  assign vld[0]   = in_valid;

  // one digit step per stage, trial bit fixed by stage position
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_q[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (rem_q[k] >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial;
        res_q[k+1] <= (res_q[k] >> 1) + BIT;
      end else begin
        rem_q[k+1] <= rem_q[k];
        res_q[k+1] <= res_q[k] >> 1;
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign root      = res_q[SQRT_STEPS][31:0];

endmodule

`default_nettype wire

// ===== sv/rmte_cordic.sv =====
// Pipelined CORDIC vectoring atan2, result in degrees with 22 fraction bits.
// Depends on rmte_pkg.
`default_nettype none

module rmte_cordic #(
  parameter int STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [32:0] y_in,
  input  wire logic signed [32:0] x_in,
  output logic                    out_valid,
  output logic signed [30:0]      deg
);
  import rmte_pkg::*;

  localparam int N = cordic_n(STAGES);

  logic signed [63:0] x_q   [0:N];
  logic signed [63:0] y_q   [0:N];
  logic signed [63:0] ang_q [0:N];
  logic               zero_q[0:N];
  logic               vld   [0:N];

  // scale by 2^26 and turn left half plane into right half plane
  logic signed [63:0] xs, ys;
  assign xs = {{5{x_in[32]}}, x_in, 26'd0};
  assign ys = {{5{y_in[32]}}, y_in, 26'd0};

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    zero_q[0] <= (x_in == '0) && (y_in == '0);
    if (xs < 0) begin
      if (ys >= 0) begin
        x_q[0]   <= ys;
        y_q[0]   <= -xs;
        ang_q[0] <= 64'sd1 <<< 61;
      end else begin
        x_q[0]   <= -ys;
        y_q[0]   <= xs;
        ang_q[0] <= -(64'sd1 <<< 61);
      end
    end else begin
      x_q[0]   <= xs;
      y_q[0]   <= ys;
      ang_q[0] <= '0;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic [63:0] TAB = atan_entry(i);
    logic signed [63:0] xsh, ysh;
    assign xsh = x_q[i] >>> i;
    assign ysh = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1]   <= x_q[i] + ysh;
        y_q[i+1]   <= y_q[i] - xsh;
        ang_q[i+1] <= ang_q[i] + $signed(TAB);
      end else begin
        x_q[i+1]   <= x_q[i] - ysh;
        y_q[i+1]   <= y_q[i] + xsh;
        ang_q[i+1] <= ang_q[i] - $signed(TAB);
      end
    end
  end

  // half turns to degrees, rounded, saturated; zero for a zero input vector
  logic signed [33:0] ang_hi;
  logic signed [41:0] d_mul, d_sh;
  assign ang_hi = ang_q[N][63:30];
  assign d_mul  = ang_hi * 42'sd180;
  assign d_sh   = (d_mul + 42'sd512) >>> 10;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[N];
  end

  always_ff @(posedge clk) begin
    if (zero_q[N]) deg <= '0;
    else if (d_sh > DEG_LIMIT) deg <= DEG_LIMIT[30:0];
    else if (d_sh < -DEG_LIMIT) deg <= 31'(-DEG_LIMIT);
    else deg <= d_sh[30:0];
  end

endmodule

`default_nettype wire

// ===== sv/rotation_matrix_to_euler_angles.sv =====
// Top level: ZYX Euler angles from seven rotation matrix elements.
// Depends on rmte_pkg, rmte_isqrt and rmte_cordic.
//
// Usage:
//   Drive r00..r11 (signed Q1.30) and pulse start. A transfer happens at
//   each clock edge with start high and busy low; busy is high only in
//   reset, so one matrix can be taken every cycle.
//   Each result appears on roll_x_deg, pitch_y_deg, yaw_z_deg and
//   is_singular for one cycle with done high, in input order.
//   The pipeline runs through the input, square and sum registers, 32
//   square-root digit stages, 1 select stage, then the CORDIC units
//   (pre-rotation, CORDIC_STAGES micro-rotations, degree conversion).
//   Throughput is one item per cycle. The receiver cannot stall; results
//   are never held. The singular threshold is written with cfg_we/cfg_wdata;
//   the user must write it only while idle, the block does not enforce it.
//   Synchronous reset empties the pipeline and sets the threshold to 1074.
`default_nettype none

module rotation_matrix_to_euler_angles #(
  parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we,
  input  wire logic [30:0]        cfg_wdata,
  input  wire logic signed [31:0] r00,
  input  wire logic signed [31:0] r10,
  input  wire logic signed [31:0] r20,
  input  wire logic signed [31:0] r21,
  input  wire logic signed [31:0] r22,
  input  wire logic signed [31:0] r12,
  input  wire logic signed [31:0] r11,
  output logic                    done,
  output logic signed [30:0]      roll_x_deg,
  output logic signed [30:0]      pitch_y_deg,
  output logic signed [30:0]      yaw_z_deg,
  output logic                    is_singular
);
  import rmte_pkg::*;

  localparam int CLAT = cordic_lat(CORDIC_STAGES);

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r10;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic signed [31:0] r12;
    logic signed [31:0] r11;
  } mat_t;

  assign busy = rst;

  // threshold register
  logic [30:0] thresh;
  always_ff @(posedge clk) begin
    if (rst) thresh <= THRESH_RESET;
    else if (cfg_we) thresh <= cfg_wdata;
  end

  // stage 1: input register
  mat_t m1, m2, m3;
  logic v1, v2, v3;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
  end
  always_ff @(posedge clk) begin
    m1 <= '{r00, r10, r20, r21, r22, r12, r11};
  end

  // stage 2: squares of |r00| and |r10|
  logic [31:0] a00, a10;
  logic [63:0] sq00, sq10;
  assign a00 = m1.r00[31] ? 32'(-m1.r00) : 32'(m1.r00);
  assign a10 = m1.r10[31] ? 32'(-m1.r10) : 32'(m1.r10);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end
  always_ff @(posedge clk) begin
    m2   <= m1;
    sq00 <= a00 * a00;
    sq10 <= a10 * a10;
  end

  // stage 3: sum of squares
  logic [63:0] ssq;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end
  always_ff @(posedge clk) begin
    m3  <= m2;
    ssq <= sq00 + sq10;
  end

  // square root, matrix carried alongside
  logic        sq_vld;
  logic [31:0] sy;
  rmte_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .radicand (ssq),
    .out_valid(sq_vld),
    .root     (sy)
  );

  mat_t dly [0:SQRT_STEPS];
  assign dly[0] = m3;
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_dly
    always_ff @(posedge clk) begin
      dly[k+1] <= dly[k];
    end
  end

  // select stage: singular test and operand choice
  mat_t               ms;
  logic               sing;
  logic               vs;
  logic signed [32:0] rx_y, rx_x, py_y, py_x, yz_y, yz_x;
  assign ms   = dly[SQRT_STEPS];
  assign sing = {1'b0, sy} < {2'b00, thresh};

  always_ff @(posedge clk) begin
    if (rst) vs <= 1'b0;
    else vs <= sq_vld;
  end
  always_ff @(posedge clk) begin
    py_y <= -{ms.r20[31], ms.r20};
    py_x <= {1'b0, sy};
    if (sing) begin
      rx_y <= -{ms.r12[31], ms.r12};
      rx_x <= {ms.r11[31], ms.r11};
      yz_y <= '0;
      yz_x <= '0;
    end else begin
      rx_y <= {ms.r21[31], ms.r21};
      rx_x <= {ms.r22[31], ms.r22};
      yz_y <= {ms.r10[31], ms.r10};
      yz_x <= {ms.r00[31], ms.r00};
    end
  end

  // singular flag travels with the CORDIC units
  logic sing_d [0:CLAT];
  always_ff @(posedge clk) begin
    sing_d[0] <= sing;
  end
  for (genvar k = 0; k < CLAT; k++) begin : g_sing
    always_ff @(posedge clk) begin
      sing_d[k+1] <= sing_d[k];
    end
  end

  // three atan2 units; yaw gets a zero vector when singular
  logic rx_vld, py_vld, yz_vld;
  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .in_valid(vs), .y_in(rx_y), .x_in(rx_x),
    .out_valid(rx_vld), .deg(roll_x_deg)
  );
  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(vs), .y_in(py_y), .x_in(py_x),
    .out_valid(py_vld), .deg(pitch_y_deg)
  );
  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .rst(rst), .in_valid(vs), .y_in(yz_y), .x_in(yz_x),
    .out_valid(yz_vld), .deg(yaw_z_deg)
  );

  assign done        = py_vld && rx_vld && yz_vld;
  assign is_singular = sing_d[CLAT];

endmodule

`default_nettype wire

// ===== sv/rmte_checker.sv =====
// Port-level checker for rotation_matrix_to_euler_angles, with its bind.
// Depends on rotation_matrix_to_euler_angles_macros.svh.
`default_nettype none
`include "rotation_matrix_to_euler_angles_macros.svh"

module rmte_checker #(
  parameter int LAT = 62
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic signed [30:0] roll_x_deg,
  input wire logic signed [30:0] yaw_z_deg,
  input wire logic               is_singular
);

  // each transfer in gives exactly one result after the fixed latency
  `RMTE_ASSERT_IMP(a_done_lat, clk, rst, done, $past(start && !busy, LAT), "result without input")
  `RMTE_ASSERT_IMP(a_in_lat, clk, rst, $past(start && !busy, LAT) && !$past(rst, LAT), done, "input lost")
  // yaw is zero in gimbal lock
  `RMTE_ASSERT_IMP(a_yaw0, clk, rst, done && is_singular, yaw_z_deg == '0, "yaw nonzero when singular")
  // roll stays within +-180 degrees
  `RMTE_ASSERT_IMP(a_roll_rng, clk, rst, done, (roll_x_deg <= 31'sd754974720) && (roll_x_deg >= -31'sd754974720), "roll out of range")
  // no stall after reset
  `RMTE_ASSERT_NXT(a_ready, clk, rst, !rst, !busy, "busy outside reset")

endmodule

bind rotation_matrix_to_euler_angles rmte_checker #(.LAT(CORDIC_STAGES + 38)) u_rmte_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .roll_x_deg(roll_x_deg), .yaw_z_deg(yaw_z_deg), .is_singular(is_singular)
);

`default_nettype wire
